/* hw/rtl/pme_pkg.sv */
`timescale 1ns / 1ps

package pme_pkg;

    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int SEG_W    = 7;
    localparam int LENGTH_W = 7;
    localparam int VALUE_W  = 16;

    // Widths large enough for the largest supported store (1024 entries)
    localparam int PTR_W    = 10;
    localparam int CNT_W    = PTR_W + 1;
    localparam int CALC_W   = 12;
    localparam int NUM_PASS = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_NONE     = 3'd0,
        FN_SWAP     = 3'd1,
        FN_RELOCATE = 3'd2,
        FN_REVERSE  = 3'd3,
        FN_SEGMENT  = 3'd4,
        FN_BLOCK    = 3'd5,
        FN_WRITE    = 3'd6,
        FN_READ     = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_READ,
        CMD_MOVE
    } cmd_op_t;

    // One pass swaps count pairs (p, q); p steps up, q steps down or up
    typedef struct packed {
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] q;
        logic             down;
        logic [CNT_W-1:0] count;
    } pass_t;

    typedef struct packed {
        cmd_op_t                   op;
        logic                      status;
        logic [PTR_W-1:0]          addr;
        logic [VALUE_W-1:0]        wval;
        pass_t [NUM_PASS-1:0]      passes;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] read_value;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WRITE,
        BK_READ,
        BK_LOAD,
        BK_RD,
        BK_WR_P,
        BK_WR_Q,
        BK_DONE
    } bk_state_t;

endpackage

/* hw/rtl/pme_fifo.sv */
`timescale 1ns / 1ps

module pme_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/pme_front.sv */
`timescale 1ns / 1ps

module pme_front #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic [pme_pkg::LENGTH_W-1:0] order_length,
    input  logic [pme_pkg::FUNC_W-1:0]   func,
    input  logic [pme_pkg::INDEX_W-1:0]  first_index,
    input  logic [pme_pkg::INDEX_W-1:0]  second_index,
    input  logic [pme_pkg::SEG_W-1:0]    segment_length,
    input  logic [pme_pkg::INDEX_W-1:0]  insert_index,
    input  logic [pme_pkg::VALUE_W-1:0]  write_value,
    output pme_pkg::cmd_t                cmd
);

    import pme_pkg::*;

    logic [CALC_W-1:0] n;
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
    logic [CALC_W-1:0] s;
    logic [CALC_W-1:0] d;
    logic [CALC_W-1:0] a_end;
    logic [CALC_W-1:0] b_end;
    logic [CALC_W-1:0] lo;
    logic [CALC_W-1:0] mid;
    logic [CALC_W-1:0] hi;
    logic              bad_index;
    pass_t             idle_pass;

    // Reverse pass over [lo, hi)
    function automatic pass_t rev_pass(input logic [CALC_W-1:0] lo_i,
                                       input logic [CALC_W-1:0] hi_i);
        pass_t            r;
        logic [CALC_W-1:0] span;
        span    = hi_i - lo_i;
        r.p     = lo_i[PTR_W-1:0];
        r.q     = PTR_W'(hi_i - 1'b1);
        r.down  = 1'b1;
        r.count = (hi_i > lo_i) ? CNT_W'(span >> 1) : '0;
        return r;
    endfunction

    always_comb
    begin
        n = (CALC_W'(order_length) > CALC_W'(MAX_ENTRIES)) ? CALC_W'(MAX_ENTRIES)
                                                           : CALC_W'(order_length);
        a     = CALC_W'(first_index);
        b     = CALC_W'(second_index);
        s     = CALC_W'(segment_length);
        d     = CALC_W'(insert_index);
        a_end = a + s;
        b_end = b + s;
        bad_index = (a >= CALC_W'(MAX_ENTRIES));

        idle_pass = '0;

        // Relocation is a rotation of [lo, hi), done as three reversals
        if (d > a)
        begin
            lo  = a;
            mid = a + s;
            hi  = d + s;
        end
        else
        begin
            lo  = d;
            mid = a;
            hi  = a + s;
        end

        cmd        = '0;
        cmd.op     = CMD_NONE;
        cmd.status = 1'b0;
        cmd.addr   = a[PTR_W-1:0];
        cmd.wval   = write_value;
        cmd.passes = {NUM_PASS{idle_pass}};

        unique case (func_t'(func))
            FN_NONE:
            begin
                cmd.op = CMD_NONE;
            end
            FN_SWAP:
            begin
                if (a >= n || b >= n)
                begin
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.op              = CMD_MOVE;
                    cmd.passes[0].p     = a[PTR_W-1:0];
                    cmd.passes[0].q     = b[PTR_W-1:0];
                    cmd.passes[0].down  = 1'b0;
                    cmd.passes[0].count = CNT_W'(1);
                end
            end
            FN_RELOCATE:
            begin
                if (a >= n || d >= n)
                begin
                    cmd.status = 1'b1;
                end
                else if (d != a)
                begin
                    // segment length is one here
                    if (d > a)
                    begin
                        cmd.passes[0] = rev_pass(a, a + 1'b1);
                        cmd.passes[1] = rev_pass(a + 1'b1, d + 1'b1);
                        cmd.passes[2] = rev_pass(a, d + 1'b1);
                    end
                    else
                    begin
                        cmd.passes[0] = rev_pass(d, a);
                        cmd.passes[1] = rev_pass(a, a + 1'b1);
                        cmd.passes[2] = rev_pass(d, a + 1'b1);
                    end
                    cmd.op = CMD_MOVE;
                end
            end
            FN_REVERSE:
            begin
                if (a >= n || b >= n || a >= b)
                begin
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.op        = CMD_MOVE;
                    cmd.passes[0] = rev_pass(a, b + 1'b1);
                end
            end
            FN_SEGMENT:
            begin
                if (s == '0 || a_end > n || d > n - s)
                begin
                    cmd.status = 1'b1;
                end
                else if (d != a)
                begin
                    cmd.op        = CMD_MOVE;
                    cmd.passes[0] = rev_pass(lo, mid);
                    cmd.passes[1] = rev_pass(mid, hi);
                    cmd.passes[2] = rev_pass(lo, hi);
                end
            end
            FN_BLOCK:
            begin
                if (s == '0 || a_end > n || b_end > n || a_end > b)
                begin
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.op              = CMD_MOVE;
                    cmd.passes[0].p     = a[PTR_W-1:0];
                    cmd.passes[0].q     = b[PTR_W-1:0];
                    cmd.passes[0].down  = 1'b0;
                    cmd.passes[0].count = CNT_W'(s);
                end
            end
            FN_WRITE:
            begin
                if (bad_index)
                begin
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.op = CMD_WRITE;
                end
            end
            FN_READ:
            begin
                if (bad_index)
                begin
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.op = CMD_READ;
                end
            end
            default:
            begin
                cmd.op = CMD_NONE;
            end
        endcase
    end

endmodule

/* hw/rtl/pme_back.sv */
`timescale 1ns / 1ps

module pme_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int ENTRY_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pme_pkg::cmd_t cmd_in,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output pme_pkg::res_t res_out,
    input  logic          res_full,
    output logic          res_push
);

    import pme_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic [1:0] LAST_PASS = 2'(NUM_PASS - 1);

    logic [ENTRY_WIDTH-1:0] mem [MAX_ENTRIES];

    bk_state_t              state_reg;
    bk_state_t              state_next;
    cmd_t                   cmd_reg;
    logic [1:0]             idx_reg;
    logic [AW-1:0]          p_reg;
    logic [AW-1:0]          q_reg;
    logic                   down_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [ENTRY_WIDTH-1:0] rdata_p_reg;
    logic [ENTRY_WIDTH-1:0] rdata_q_reg;

    pass_t                  cur_pass;
    logic                   last_pass;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          raddr_p;
    logic [AW-1:0]          raddr_q;
    logic [ENTRY_WIDTH-1:0] wval_ext;
    logic [VALUE_W-1:0]     rval16;

    assign cur_pass  = cmd_reg.passes[idx_reg];
    assign last_pass = (idx_reg == LAST_PASS);

    generate
        if (ENTRY_WIDTH > VALUE_W)
        begin : g_wide
            assign wval_ext = {{(ENTRY_WIDTH-VALUE_W){1'b0}}, cmd_reg.wval};
            assign rval16   = rdata_p_reg[VALUE_W-1:0];
        end
        else if (ENTRY_WIDTH < VALUE_W)
        begin : g_narrow
            assign wval_ext = cmd_reg.wval[ENTRY_WIDTH-1:0];
            assign rval16   = {{(VALUE_W-ENTRY_WIDTH){1'b0}}, rdata_p_reg};
        end
        else
        begin : g_equal
            assign wval_ext = cmd_reg.wval;
            assign rval16   = rdata_p_reg;
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd_in.op)
                        CMD_NONE:  state_next = BK_DONE;
                        CMD_WRITE: state_next = BK_WRITE;
                        CMD_READ:  state_next = BK_READ;
                        CMD_MOVE:  state_next = BK_LOAD;
                        default:   state_next = BK_DONE;
                    endcase
                end
            end
            BK_WRITE: state_next = BK_DONE;
            BK_READ:  state_next = BK_DONE;
            BK_LOAD:
            begin
                if (cur_pass.count != '0)
                begin
                    state_next = BK_RD;
                end
                else if (last_pass)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_RD:   state_next = BK_WR_P;
            BK_WR_P: state_next = BK_WR_Q;
            BK_WR_Q:
            begin
                if (cnt_reg != CNT_W'(1))
                begin
                    state_next = BK_RD;
                end
                else if (last_pass)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_DONE:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = p_reg;
        mem_wdata = rdata_q_reg;
        mem_re    = 1'b0;
        raddr_p   = p_reg;
        raddr_q   = q_reg;
        unique case (state_reg)
            BK_IDLE:  cmd_pop = !cmd_empty;
            BK_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = cmd_reg.addr[AW-1:0];
                mem_wdata = wval_ext;
            end
            BK_READ:
            begin
                mem_re  = 1'b1;
                raddr_p = cmd_reg.addr[AW-1:0];
            end
            BK_LOAD:  mem_re = 1'b0;
            BK_RD:    mem_re = 1'b1;
            BK_WR_P:  mem_we = 1'b1;
            BK_WR_Q:
            begin
                mem_we    = 1'b1;
                mem_waddr = q_reg;
                mem_wdata = rdata_p_reg;
            end
            BK_DONE:  res_push = !res_full;
            default:  cmd_pop = 1'b0;
        endcase
    end

    assign res_out.status     = cmd_reg.status;
    assign res_out.read_value = (cmd_reg.op == CMD_READ) ? rval16 : '0;

    // Order store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_p_reg <= mem[raddr_p];
            rdata_q_reg <= mem[raddr_q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_in;
        end
        if (state_reg == BK_LOAD)
        begin
            p_reg    <= cur_pass.p[AW-1:0];
            q_reg    <= cur_pass.q[AW-1:0];
            down_reg <= cur_pass.down;
            cnt_reg  <= cur_pass.count;
        end
        else if (state_reg == BK_WR_Q)
        begin
            p_reg   <= p_reg + 1'b1;
            q_reg   <= down_reg ? (q_reg - 1'b1) : (q_reg + 1'b1);
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == BK_LOAD && cur_pass.count == '0 && !last_pass)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == BK_WR_Q && cnt_reg == CNT_W'(1) && !last_pass)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE || state_reg == BK_DONE) |-> !mem_we)
        else $error("store written outside a command");

    a_push_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (state_reg == BK_DONE && !res_full))
        else $error("result pushed outside done state");

    a_pair_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RD) |-> (cnt_reg != '0))
        else $error("pair swap started with zero count");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != BK_IDLE))
        else $error("command popped but engine stayed idle");

endmodule

/* hw/rtl/permutation_move_engine.sv */
// Throughput: one item at a time in the back end, the next one starting the cycle after
// the result is queued; up to two commands wait ahead of it.
// Reset: queues and control clear, order_length becomes 0; store contents stay undefined.
`timescale 1ns / 1ps

module permutation_move_engine #(
    parameter int MAX_ENTRIES = 64,
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pme_pkg::LENGTH_W-1:0] cfg_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic [pme_pkg::FUNC_W-1:0]   func,
    input  logic [pme_pkg::INDEX_W-1:0]  first_index,
    input  logic [pme_pkg::INDEX_W-1:0]  second_index,
    input  logic [pme_pkg::SEG_W-1:0]    segment_length,
    input  logic [pme_pkg::INDEX_W-1:0]  insert_index,
    input  logic [pme_pkg::VALUE_W-1:0]  write_value,
    output logic                         empty,
    input  logic                         pop,
    output logic                         status,
    output logic [pme_pkg::VALUE_W-1:0]  read_value
);

    import pme_pkg::*;

    logic [LENGTH_W-1:0] order_length_reg;
    cmd_t                front_cmd;
    cmd_t                queued_cmd;
    logic                cmd_empty;
    logic                cmd_pop;
    res_t                back_res;
    res_t                head_res;
    logic                res_full;
    logic                res_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            order_length_reg <= cfg_wdata;
        end
    end

    pme_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .order_length   (order_length_reg),
        .func           (func),
        .first_index    (first_index),
        .second_index   (second_index),
        .segment_length (segment_length),
        .insert_index   (insert_index),
        .write_value    (write_value),
        .cmd            (front_cmd)
    );

    pme_fifo #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (queued_cmd),
        .empty (cmd_empty)
    );

    pme_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (queued_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_out   (back_res),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    pme_fifo #(
        .WIDTH ($bits(res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (head_res),
        .empty (empty)
    );

    assign status     = head_res.status;
    assign read_value = head_res.read_value;

endmodule

/* tb/sv/permutation_move_engine_tb.sv */
`timescale 1ns / 1ps

module permutation_move_engine_tb;

    import pme_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int NUM_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 98;
    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        func_t             op;
        logic [INDEX_W-1:0] first;
        logic [INDEX_W-1:0] second;
        logic [SEG_W-1:0]   seg_len;
        logic [INDEX_W-1:0] ins;
        logic [VALUE_W-1:0] wval;
    } move_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LENGTH_W-1:0] cfg_wdata = '0;
    logic                push = 1'b0;
    logic                full;
    logic [FUNC_W-1:0]   func = '0;
    logic [INDEX_W-1:0]  first_index = '0;
    logic [INDEX_W-1:0]  second_index = '0;
    logic [SEG_W-1:0]    segment_length = '0;
    logic [INDEX_W-1:0]  insert_index = '0;
    logic [VALUE_W-1:0]  write_value = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic                status;
    logic [VALUE_W-1:0]  read_value;

    move_item_t          pending_moves[$];
    res_t                expected_results[$];
    res_t                head_result;
    logic [VALUE_W-1:0]  order_model[STORE_DEPTH];
    int                  length_model = 0;
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  stall_req = 0;
    int                  stall_served = 0;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;

    permutation_move_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .func           (func),
        .first_index    (first_index),
        .second_index   (second_index),
        .segment_length (segment_length),
        .insert_index   (insert_index),
        .write_value    (write_value),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .read_value     (read_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Take [start, start+len) out and put it back in at position dest of the rest
    function automatic void shift_segment(int total, int start, int len, int dest);
        logic [VALUE_W-1:0] seg_buf[STORE_DEPTH];
        logic [VALUE_W-1:0] rest_buf[STORE_DEPTH];
        int nrest;
        int k;
        nrest = 0;
        k = 0;
        for (int i = 0; i < len; i++)
            seg_buf[i] = order_model[start + i];
        for (int i = 0; i < total; i++)
            if (i < start || i >= start + len)
            begin
                rest_buf[nrest] = order_model[i];
                nrest++;
            end
        for (int i = 0; i < dest; i++)
        begin
            order_model[k] = rest_buf[i];
            k++;
        end
        for (int i = 0; i < len; i++)
        begin
            order_model[k] = seg_buf[i];
            k++;
        end
        for (int i = dest; i < nrest; i++)
        begin
            order_model[k] = rest_buf[i];
            k++;
        end
    endfunction

    function automatic res_t apply_move(move_item_t it);
        res_t r;
        int n;
        int a;
        int b;
        int seg;
        int ins;
        logic [VALUE_W-1:0] t;
        r.status = 1'b0;
        r.read_value = '0;
        n = (length_model > STORE_DEPTH) ? STORE_DEPTH : length_model;
        a = int'(it.first);
        b = int'(it.second);
        seg = int'(it.seg_len);
        ins = int'(it.ins);
        case (it.op)
            FN_SWAP:
                if (a >= n || b >= n)
                    r.status = 1'b1;
                else
                begin
                    t = order_model[a];
                    order_model[a] = order_model[b];
                    order_model[b] = t;
                end
            FN_RELOCATE:
                if (a >= n || ins >= n)
                    r.status = 1'b1;
                else
                    shift_segment(n, a, 1, ins);
            FN_REVERSE:
                if (a >= n || b >= n || a >= b)
                    r.status = 1'b1;
                else
                    while (a < b)
                    begin
                        t = order_model[a];
                        order_model[a] = order_model[b];
                        order_model[b] = t;
                        a++;
                        b--;
                    end
            FN_SEGMENT:
                if (seg == 0 || a + seg > n || ins > n - seg)
                    r.status = 1'b1;
                else
                    shift_segment(n, a, seg, ins);
            FN_BLOCK:
                if (seg == 0 || a + seg > n || b + seg > n || a + seg > b)
                    r.status = 1'b1;
                else
                    for (int i = 0; i < seg; i++)
                    begin
                        t = order_model[a + i];
                        order_model[a + i] = order_model[b + i];
                        order_model[b + i] = t;
                    end
            FN_WRITE:
                if (a >= STORE_DEPTH)
                    r.status = 1'b1;
                else
                    order_model[a] = it.wval;
            FN_READ:
                if (a >= STORE_DEPTH)
                    r.status = 1'b1;
                else
                    r.read_value = order_model[a];
            default:
                r.status = 1'b0;
        endcase
        return r;
    endfunction

    function automatic move_item_t mk(func_t op, int a, int b, int seg, int ins, int v);
        move_item_t it;
        it.op = op;
        it.first = a[INDEX_W-1:0];
        it.second = b[INDEX_W-1:0];
        it.seg_len = seg[SEG_W-1:0];
        it.ins = ins[INDEX_W-1:0];
        it.wval = v[VALUE_W-1:0];
        return it;
    endfunction

    // Append a transaction to the tail of the pending list
    function automatic void add_item(move_item_t it);
        pending_moves.insert(pending_moves.size(), it);
    endfunction

    // Mostly legal moves for the current length, some off by one, the rest noise
    function automatic move_item_t random_move(int n);
        move_item_t it;
        int pick;
        int a;
        int seg;
        it = mk(func_t'($urandom_range(7)), $urandom_range(63), $urandom_range(63),
                $urandom_range(127), $urandom_range(63), $urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 12)
            return it;
        case (it.op)
            FN_SWAP:
                if (n >= 1)
                begin
                    it.first = INDEX_W'($urandom_range(n - 1));
                    it.second = INDEX_W'($urandom_range(n - 1));
                end
            FN_RELOCATE:
                if (n >= 1)
                begin
                    it.first = INDEX_W'($urandom_range(n - 1));
                    it.ins = INDEX_W'($urandom_range(n - 1));
                end
            FN_REVERSE:
                if (n >= 2)
                begin
                    a = $urandom_range(n - 2);
                    it.first = INDEX_W'(a);
                    it.second = INDEX_W'($urandom_range(n - 1, a + 1));
                end
            FN_SEGMENT:
                if (n >= 1)
                begin
                    seg = $urandom_range(n, 1);
                    it.seg_len = SEG_W'(seg);
                    it.first = INDEX_W'($urandom_range(n - seg));
                    it.ins = INDEX_W'($urandom_range(n - seg));
                end
            FN_BLOCK:
                if (n >= 2)
                begin
                    seg = $urandom_range(n / 2, 1);
                    a = $urandom_range(n - 2 * seg);
                    it.seg_len = SEG_W'(seg);
                    it.first = INDEX_W'(a);
                    it.second = INDEX_W'($urandom_range(n - seg, a + seg));
                end
            default:
                it.op = it.op;
        endcase
        if (pick < 22)
            case ($urandom_range(3))
                0: it.first = it.first + 1'b1;
                1: it.second = it.second + 1'b1;
                2: it.seg_len = it.seg_len + 1'b1;
                default: it.ins = it.ins + 1'b1;
            endcase
        return it;
    endfunction

    // Driver: offer the oldest pending transaction, predict it once accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                expected_results.insert(expected_results.size(),
                                        apply_move(pending_moves[0]));
                void'(pending_moves.pop_front());
            end
            if (pending_moves.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push <= 1'b1;
                func <= pending_moves[0].op;
                first_index <= pending_moves[0].first;
                second_index <= pending_moves[0].second;
                segment_length <= pending_moves[0].seg_len;
                insert_index <= pending_moves[0].ins;
                write_value <= pending_moves[0].wval;
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d read_value %0h", status, read_value);
                    error_count++;
                end
                else
                begin
                    head_result = expected_results.pop_front();
                    if (status !== head_result.status)
                    begin
                        $error("status: expected %0d, got %0d", head_result.status, status);
                        error_count++;
                    end
                    if (read_value !== head_result.read_value)
                    begin
                        $error("read_value: expected %0h, got %0h",
                               head_result.read_value, read_value);
                        error_count++;
                    end
                end
            end
            if (stall_req != stall_served)
            begin
                stall_served = stall_req;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic set_length(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[LENGTH_W-1:0];
        length_model = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_moves.size() != 0 || expected_results.size() != 0);
    endtask

    initial
    begin
        int lengths[NUM_PHASES];
        int len;
        lengths = '{64, 127, 1, 8, 2, 0, 16, 65, 5, 32, 3, 64};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        set_length(64);

        // load every entry so that no read touches an unwritten one
        for (int i = 0; i < STORE_DEPTH; i++)
            add_item(mk(FN_WRITE, i, 0, 0, 0, $urandom_range(16'hFFFF)));

        add_item(mk(FN_NONE, 63, 63, 127, 63, 16'hFFFF));
        add_item(mk(FN_SWAP, 0, 63, 0, 0, 0));
        add_item(mk(FN_SWAP, 5, 5, 0, 0, 0));
        add_item(mk(FN_RELOCATE, 0, 0, 0, 63, 0));
        add_item(mk(FN_RELOCATE, 63, 0, 0, 0, 0));
        add_item(mk(FN_REVERSE, 0, 63, 0, 0, 0));
        add_item(mk(FN_REVERSE, 10, 10, 0, 0, 0));
        add_item(mk(FN_REVERSE, 40, 20, 0, 0, 0));
        add_item(mk(FN_SEGMENT, 0, 0, 0, 0, 0));
        add_item(mk(FN_SEGMENT, 0, 0, 64, 0, 0));
        add_item(mk(FN_SEGMENT, 1, 0, 64, 0, 0));
        add_item(mk(FN_SEGMENT, 60, 0, 4, 60, 0));
        add_item(mk(FN_SEGMENT, 3, 0, 10, 55, 0));
        add_item(mk(FN_SEGMENT, 0, 0, 127, 0, 0));
        add_item(mk(FN_BLOCK, 0, 32, 32, 0, 0));
        add_item(mk(FN_BLOCK, 0, 2, 4, 0, 0));
        add_item(mk(FN_BLOCK, 0, 4, 4, 0, 0));
        add_item(mk(FN_BLOCK, 10, 60, 8, 0, 0));
        add_item(mk(FN_BLOCK, 0, 1, 0, 0, 0));
        add_item(mk(FN_WRITE, 63, 0, 0, 0, 16'hFFFF));
        add_item(mk(FN_WRITE, 0, 0, 0, 0, 0));
        add_item(mk(FN_READ, 63, 0, 0, 0, 0));
        add_item(mk(FN_READ, 0, 0, 0, 0, 0));
        add_item(mk(FN_READ, 31, 0, 0, 0, 0));
        add_item(mk(FN_READ, 62, 0, 0, 0, 0));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            len = (p == NUM_PHASES - 1) ? $urandom_range(127) : lengths[p];
            set_length(len);
            if (p < 4)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 46;
            end
            else if (p < 8)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // hold off the receiver so the block backs up and stalls its input
            if (p == 1 || p == 5)
                stall_req++;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                add_item(random_move(len > STORE_DEPTH ? STORE_DEPTH : len));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
